// ===== sv/sps_pkg.sv =====
// shared widths, reset values, codes and unit request and response types for the seek and pursuit step
`timescale 1ns / 1ps
`default_nettype none
package sps_pkg;

    // field and datapath widths
    localparam int POS_W   = 21;  // Q12.8 position
    localparam int SPD_W   = 16;  // Q8.8 speed
    localparam int MASS_W  = 8;
    localparam int DIFF_W  = POS_W + 1;  // difference of two positions
    localparam int VEL_W   = 18;  // velocity magnitude never exceeds 65535
    localparam int MUL_W   = 24;  // signed multiplier operand
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIV_NW  = 38;  // dividend magnitude bits
    localparam int DIV_DW  = 22;  // divisor bits
    localparam int SQ_RW   = 44;  // radicand bits
    localparam int SQ_QW   = SQ_RW / 2;  // root bits
    localparam int CFG_IW  = 3;

    // register reset values
    localparam logic [SPD_W-1:0]         DESIRED_SPEED_RST = 16'd2560;
    localparam logic [SPD_W-1:0]         MAX_SPEED_RST     = 16'd2560;
    localparam logic [MASS_W-1:0]        MASS_RST          = 8'd50;
    localparam logic [SPD_W-1:0]         LEAD_SPEED_RST    = 16'd512;
    localparam logic signed [POS_W-1:0]  EVADER_START_RST  = 21'sd0;
    localparam logic signed [POS_W-1:0]  PURSUER_START_RST = 21'sd51200;

    // configuration register indexes
    typedef enum logic [CFG_IW-1:0] {
        CFG_DESIRED_SPEED   = 3'd0,
        CFG_MAX_SPEED       = 3'd1,
        CFG_MASS            = 3'd2,
        CFG_LEAD_SPEED      = 3'd3,
        CFG_EVADER_START_X  = 3'd4,
        CFG_EVADER_START_Y  = 3'd5,
        CFG_PURSUER_START_X = 3'd6,
        CFG_PURSUER_START_Y = 3'd7
    } t_cfg_idx;

    // divider request and response
    typedef struct packed {
        logic                      start;
        logic signed [PROD_W-1:0]  num;
        logic [DIV_DW-1:0]         den;
    } t_div_req;

    typedef struct packed {
        logic                      busy;
        logic                      done;
        logic signed [DIV_NW:0]    quo;
    } t_div_rsp;

    // square root request and response
    typedef struct packed {
        logic               start;
        logic [SQ_RW-1:0]   rad;
    } t_sq_req;

    typedef struct packed {
        logic               busy;
        logic               done;
        logic [SQ_QW-1:0]   root;
    } t_sq_rsp;

endpackage
`default_nettype wire

// ===== sv/sps_if.sv =====
// request and response channel interfaces of the seek and pursuit step
`timescale 1ns / 1ps
`default_nettype none
interface sps_req_if import sps_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic signed [POS_W-1:0]   goal_x;
    logic signed [POS_W-1:0]   goal_y;

    modport source (output valid, mode, goal_x, goal_y, input ready);
    modport sink   (input valid, mode, goal_x, goal_y, output ready);
endinterface

interface sps_rsp_if import sps_pkg::*; ;
    logic                      valid;
    logic                      ready;
    logic signed [POS_W-1:0]   evader_pos_x;
    logic signed [POS_W-1:0]   evader_pos_y;
    logic signed [POS_W-1:0]   pursuer_pos_x;
    logic signed [POS_W-1:0]   pursuer_pos_y;

    modport source (output valid, evader_pos_x, evader_pos_y, pursuer_pos_x, pursuer_pos_y,
                    input ready);
    modport sink   (input valid, evader_pos_x, evader_pos_y, pursuer_pos_x, pursuer_pos_y,
                    output ready);
endinterface
`default_nettype wire

// ===== sv/sps_div.sv =====
// radix-2 restoring divider, signed dividend by positive divisor, truncating toward zero
`timescale 1ns / 1ps
`default_nettype none
module sps_div import sps_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_div_req  i_req,
    output t_div_rsp       o_rsp
);

    localparam int CNT_W = $clog2(DIV_NW + 1);

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [DIV_NW-1:0]     r_mag;
    logic [DIV_DW-1:0]     r_rem;
    logic [DIV_DW-1:0]     r_den;
    logic                  r_neg;

    logic [PROD_W-1:0]     num_abs;
    logic [DIV_DW:0]       w;
    logic [DIV_DW:0]       w_sub;
    logic                  ge;
    logic signed [DIV_NW:0] mag_s;

    // magnitude of the dividend
    assign num_abs = i_req.num[PROD_W-1] ? PROD_W'(-i_req.num) : PROD_W'(i_req.num);

    // one quotient bit per cycle
    assign w     = {r_rem, r_mag[DIV_NW-1]};
    assign w_sub = w - {1'b0, r_den};
    assign ge    = (w >= {1'b0, r_den});

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_mag <= num_abs[DIV_NW-1:0];
            r_rem <= '0;
            r_den <= i_req.den;
            r_neg <= i_req.num[PROD_W-1];
        end else if (r_busy) begin
            r_rem <= ge ? w_sub[DIV_DW-1:0] : w[DIV_DW-1:0];
            r_mag <= {r_mag[DIV_NW-2:0], ge};
        end
    end

    assign mag_s       = $signed({1'b0, r_mag});
    assign o_rsp.busy  = r_busy;
    assign o_rsp.done  = r_done;
    assign o_rsp.quo   = r_neg ? -mag_s : mag_s;

endmodule
`default_nettype wire

// ===== sv/sps_isqrt.sv =====
// digit-by-digit integer square root, two radicand bits per cycle
`timescale 1ns / 1ps
`default_nettype none
module sps_isqrt import sps_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_sq_req  i_req,
    output t_sq_rsp       o_rsp
);

    localparam int CNT_W = $clog2(SQ_QW + 1);
    localparam int REM_W = SQ_QW + 2;

    logic                  r_busy;
    logic                  r_done;
    logic [CNT_W-1:0]      r_cnt;
    logic [SQ_RW-1:0]      r_rad;
    logic [REM_W-1:0]      r_rem;
    logic [SQ_QW-1:0]      r_root;

    logic [REM_W+1:0]      w;
    logic [REM_W+1:0]      trial;
    logic [REM_W+1:0]      w_sub;
    logic                  ge;

    // trial subtract of (root << 2) | 1
    assign w     = {r_rem, r_rad[SQ_RW-1 -: 2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign w_sub = w - trial;
    assign ge    = (w >= trial);

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(SQ_QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.rad;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[SQ_RW-3:0], 2'b00};
            r_rem  <= ge ? w_sub[REM_W-1:0] : w[REM_W-1:0];
            r_root <= {r_root[SQ_QW-2:0], ge};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule
`default_nettype wire

// ===== sv/seek_pursuit_steering_step.sv =====
// seek and pursuit steering tick: sequencer, shared multiplier, divider and square root
// restart request: loads the start positions and zero velocities, then passes through ST_OUT to the result register
// tick request: 5 to 13 divides through the one divider plus 3 to 5 square roots;
//   the divider dominates
// one request at a time; the next is taken once the result is in the output register
// synchronous active-low reset loads the register defaults, start positions, zero velocity
`timescale 1ns / 1ps
`default_nettype none
module seek_pursuit_steering_step import sps_pkg::*; (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_IW-1:0]   i_cfg_idx,
    input  wire logic [POS_W-1:0]    i_cfg_data,
    sps_req_if.sink                  i_req,
    sps_rsp_if.source                o_rsp
);

    typedef enum logic [5:0] {
        ST_IDLE, ST_DIFF, ST_SQX, ST_SQY, ST_LEN, ST_LENW,
        ST_WXM, ST_WXD, ST_WXW, ST_WYM, ST_WYD, ST_WYW,
        ST_NXD, ST_NXW, ST_NYD, ST_NYW,
        ST_CX, ST_CY, ST_CM, ST_CCMP, ST_CLW,
        ST_CXM, ST_CXD, ST_CXW, ST_CYM, ST_CYD, ST_CYW,
        ST_UPD, ST_PTD, ST_PTW, ST_PFX, ST_PFY, ST_PFW, ST_OUT
    } t_state;

    localparam logic signed [VEL_W-1:0] VEL_LIM = VEL_W'(65535);

    // configuration registers
    logic [SPD_W-1:0]          r_ds, r_ms, r_ls;
    logic [MASS_W-1:0]         r_mass;
    logic signed [POS_W-1:0]   r_esx, r_esy, r_psx, r_psy;

    // agent state, index 0 evader, 1 pursuer
    logic signed [POS_W-1:0]   r_px [2];
    logic signed [POS_W-1:0]   r_py [2];
    logic signed [VEL_W-1:0]   r_vx [2];
    logic signed [VEL_W-1:0]   r_vy [2];

    // sequencer and work registers
    t_state                    r_state;
    logic                      r_agent;
    logic                      r_pred;
    logic signed [POS_W-1:0]   r_tx, r_ty;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic signed [PROD_W-1:0]  r_prod;
    logic [SQ_RW-1:0]          r_acc;
    logic [SQ_QW-1:0]          r_len;
    logic signed [VEL_W-1:0]   r_wx, r_wy, r_nx, r_ny;
    logic [SQ_QW-1:0]          r_t;

    // result register
    logic                      r_ovalid;
    logic signed [POS_W-1:0]   r_oex, r_oey, r_opx, r_opy;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    t_div_req                  div_req;
    t_div_rsp                  div_rsp;
    t_sq_req                   sq_req;
    t_sq_rsp                   sq_rsp;
    logic [MASS_W-1:0]         m_eff;
    logic [SPD_W-1:0]          ls_eff;
    logic signed [POS_W-1:0]   cur_px, cur_py, new_px, new_py;
    logic signed [VEL_W-1:0]   cur_vx, cur_vy;
    logic signed [POS_W-1:0]   fx_sat, fy_sat;

    // clamp a wide sum into the position range
    function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [PROD_W-1:0] v);
        logic ovf;
        ovf = (v[PROD_W-1:POS_W-1] != {(PROD_W-POS_W+1){v[PROD_W-1]}});
        if (!ovf) begin
            return v[POS_W-1:0];
        end else if (v[PROD_W-1]) begin
            return {1'b1, {(POS_W-1){1'b0}}};
        end else begin
            return {1'b0, {(POS_W-1){1'b1}}};
        end
    endfunction

    assign m_eff  = (r_mass == '0) ? MASS_W'(1) : r_mass;
    assign ls_eff = (r_ls == '0) ? SPD_W'(1) : r_ls;
    assign cur_px = r_px[r_agent];
    assign cur_py = r_py[r_agent];
    assign cur_vx = r_vx[r_agent];
    assign cur_vy = r_vy[r_agent];
    assign new_px = sat_pos(PROD_W'(cur_px) + PROD_W'(r_nx));
    assign new_py = sat_pos(PROD_W'(cur_py) + PROD_W'(r_ny));
    assign fx_sat = sat_pos(PROD_W'(r_px[0]) + r_prod);
    assign fy_sat = sat_pos(PROD_W'(r_py[0]) + r_prod);

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_SQX:  begin mul_a = MUL_W'(r_dx);     mul_b = MUL_W'(r_dx); end
            ST_SQY:  begin mul_a = MUL_W'(r_dy);     mul_b = MUL_W'(r_dy); end
            ST_WXM:  begin mul_a = MUL_W'(r_dx);     mul_b = MUL_W'(r_ds); end
            ST_WYM:  begin mul_a = MUL_W'(r_dy);     mul_b = MUL_W'(r_ds); end
            ST_CX:   begin mul_a = MUL_W'(r_nx);     mul_b = MUL_W'(r_nx); end
            ST_CY:   begin mul_a = MUL_W'(r_ny);     mul_b = MUL_W'(r_ny); end
            ST_CM:   begin mul_a = MUL_W'(r_ms);     mul_b = MUL_W'(r_ms); end
            ST_CXM:  begin mul_a = MUL_W'(r_nx);     mul_b = MUL_W'(r_ms); end
            ST_CYM:  begin mul_a = MUL_W'(r_ny);     mul_b = MUL_W'(r_ms); end
            ST_PFX:  begin mul_a = MUL_W'(r_vx[0]);  mul_b = MUL_W'(r_t);  end
            ST_PFY:  begin mul_a = MUL_W'(r_vy[0]);  mul_b = MUL_W'(r_t);  end
            default: begin mul_a = '0;               mul_b = '0;           end
        endcase
    end

    // divider and square root requests
    always_comb begin
        div_req.start = 1'b0;
        div_req.num   = r_prod;
        div_req.den   = DIV_DW'(r_len);
        sq_req.start  = 1'b0;
        sq_req.rad    = r_acc;
        unique case (r_state)
            ST_WXD, ST_WYD, ST_CXD, ST_CYD: begin
                div_req.start = 1'b1;
            end
            ST_NXD: begin
                div_req.start = 1'b1;
                div_req.num   = PROD_W'(r_wx) - PROD_W'(cur_vx);
                div_req.den   = DIV_DW'(m_eff);
            end
            ST_NYD: begin
                div_req.start = 1'b1;
                div_req.num   = PROD_W'(r_wy) - PROD_W'(cur_vy);
                div_req.den   = DIV_DW'(m_eff);
            end
            ST_PTD: begin
                div_req.start = 1'b1;
                div_req.num   = PROD_W'(r_len);
                div_req.den   = DIV_DW'(ls_eff);
            end
            ST_LEN: begin
                sq_req.start = 1'b1;
                sq_req.rad   = r_acc + r_prod[SQ_RW-1:0];
            end
            ST_CCMP: begin
                sq_req.start = (r_acc > r_prod[SQ_RW-1:0]);
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    sps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    sps_isqrt u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    // product register after the multiplier
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ds   <= DESIRED_SPEED_RST;
            r_ms   <= MAX_SPEED_RST;
            r_mass <= MASS_RST;
            r_ls   <= LEAD_SPEED_RST;
            r_esx  <= EVADER_START_RST;
            r_esy  <= EVADER_START_RST;
            r_psx  <= PURSUER_START_RST;
            r_psy  <= PURSUER_START_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_DESIRED_SPEED:   r_ds   <= i_cfg_data[SPD_W-1:0];
                CFG_MAX_SPEED:       r_ms   <= i_cfg_data[SPD_W-1:0];
                CFG_MASS:            r_mass <= i_cfg_data[MASS_W-1:0];
                CFG_LEAD_SPEED:      r_ls   <= i_cfg_data[SPD_W-1:0];
                CFG_EVADER_START_X:  r_esx  <= i_cfg_data;
                CFG_EVADER_START_Y:  r_esy  <= i_cfg_data;
                CFG_PURSUER_START_X: r_psx  <= i_cfg_data;
                CFG_PURSUER_START_Y: r_psy  <= i_cfg_data;
            endcase
        end
    end

    // sequencer, agent state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_agent  <= 1'b0;
            r_pred   <= 1'b0;
            r_ovalid <= 1'b0;
            r_px[0]  <= EVADER_START_RST;
            r_py[0]  <= EVADER_START_RST;
            r_px[1]  <= PURSUER_START_RST;
            r_py[1]  <= PURSUER_START_RST;
            r_vx[0]  <= '0;
            r_vy[0]  <= '0;
            r_vx[1]  <= '0;
            r_vy[1]  <= '0;
        end else begin
            // result taken and no new one loaded this cycle
            if (r_ovalid && o_rsp.ready && (r_state != ST_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        if (i_req.mode) begin
                            r_px[0] <= r_esx;
                            r_py[0] <= r_esy;
                            r_px[1] <= r_psx;
                            r_py[1] <= r_psy;
                            r_vx[0] <= '0;
                            r_vy[0] <= '0;
                            r_vx[1] <= '0;
                            r_vy[1] <= '0;
                            r_state <= ST_OUT;
                        end else begin
                            r_agent <= 1'b0;
                            r_pred  <= 1'b0;
                            r_tx    <= i_req.goal_x;
                            r_ty    <= i_req.goal_y;
                            r_state <= ST_DIFF;
                        end
                    end
                end
                // offset to target
                ST_DIFF: begin
                    r_dx    <= DIFF_W'(r_tx) - DIFF_W'(cur_px);
                    r_dy    <= DIFF_W'(r_ty) - DIFF_W'(cur_py);
                    r_state <= ST_SQX;
                end
                ST_SQX: r_state <= ST_SQY;
                ST_SQY: begin
                    r_acc   <= r_prod[SQ_RW-1:0];
                    r_state <= ST_LEN;
                end
                ST_LEN: r_state <= ST_LENW;
                ST_LENW: begin
                    if (sq_rsp.done) begin
                        r_len <= sq_rsp.root;
                        if (r_pred) begin
                            r_state <= ST_PTD;
                        end else if (sq_rsp.root == '0) begin
                            r_wx    <= '0;
                            r_wy    <= '0;
                            r_state <= ST_NXD;
                        end else begin
                            r_state <= ST_WXM;
                        end
                    end
                end
                // desired velocity
                ST_WXM: r_state <= ST_WXD;
                ST_WXD: r_state <= ST_WXW;
                ST_WXW: begin
                    if (div_rsp.done) begin
                        r_wx    <= VEL_W'(div_rsp.quo);
                        r_state <= ST_WYM;
                    end
                end
                ST_WYM: r_state <= ST_WYD;
                ST_WYD: r_state <= ST_WYW;
                ST_WYW: begin
                    if (div_rsp.done) begin
                        r_wy    <= VEL_W'(div_rsp.quo);
                        r_state <= ST_NXD;
                    end
                end
                // steering over mass
                ST_NXD: r_state <= ST_NXW;
                ST_NXW: begin
                    if (div_rsp.done) begin
                        r_nx    <= cur_vx + VEL_W'(div_rsp.quo);
                        r_state <= ST_NYD;
                    end
                end
                ST_NYD: r_state <= ST_NYW;
                ST_NYW: begin
                    if (div_rsp.done) begin
                        r_ny    <= cur_vy + VEL_W'(div_rsp.quo);
                        r_state <= ST_CX;
                    end
                end
                // speed clamp
                ST_CX: r_state <= ST_CY;
                ST_CY: begin
                    r_acc   <= r_prod[SQ_RW-1:0];
                    r_state <= ST_CM;
                end
                ST_CM: begin
                    r_acc   <= r_acc + r_prod[SQ_RW-1:0];
                    r_state <= ST_CCMP;
                end
                ST_CCMP: begin
                    r_state <= (r_acc > r_prod[SQ_RW-1:0]) ? ST_CLW : ST_UPD;
                end
                ST_CLW: begin
                    if (sq_rsp.done) begin
                        r_len   <= sq_rsp.root;
                        r_state <= ST_CXM;
                    end
                end
                ST_CXM: r_state <= ST_CXD;
                ST_CXD: r_state <= ST_CXW;
                ST_CXW: begin
                    if (div_rsp.done) begin
                        r_nx    <= VEL_W'(div_rsp.quo);
                        r_state <= ST_CYM;
                    end
                end
                ST_CYM: r_state <= ST_CYD;
                ST_CYD: r_state <= ST_CYW;
                ST_CYW: begin
                    if (div_rsp.done) begin
                        r_ny    <= VEL_W'(div_rsp.quo);
                        r_state <= ST_UPD;
                    end
                end
                // write back, then predict for the pursuer or finish
                ST_UPD: begin
                    r_vx[r_agent] <= r_nx;
                    r_vy[r_agent] <= r_ny;
                    r_px[r_agent] <= new_px;
                    r_py[r_agent] <= new_py;
                    if (!r_agent) begin
                        r_agent <= 1'b1;
                        r_pred  <= 1'b1;
                        r_tx    <= new_px;
                        r_ty    <= new_py;
                        r_state <= ST_DIFF;
                    end else begin
                        r_state <= ST_OUT;
                    end
                end
                // lead ticks and predicted point
                ST_PTD: r_state <= ST_PTW;
                ST_PTW: begin
                    if (div_rsp.done) begin
                        r_t     <= div_rsp.quo[SQ_QW-1:0];
                        r_state <= ST_PFX;
                    end
                end
                ST_PFX: r_state <= ST_PFY;
                ST_PFY: begin
                    r_tx    <= fx_sat;
                    r_state <= ST_PFW;
                end
                ST_PFW: begin
                    r_ty    <= fy_sat;
                    r_pred  <= 1'b0;
                    r_state <= ST_DIFF;
                end
                ST_OUT: begin
                    if (!r_ovalid || o_rsp.ready) begin
                        r_ovalid <= 1'b1;
                        r_oex    <= r_px[0];
                        r_oey    <= r_py[0];
                        r_opx    <= r_px[1];
                        r_opy    <= r_py[1];
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_ovalid;
    assign o_rsp.evader_pos_x  = r_oex;
    assign o_rsp.evader_pos_y  = r_oey;
    assign o_rsp.pursuer_pos_x = r_opx;
    assign o_rsp.pursuer_pos_y = r_opy;

    // shared units are only started when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |-> !div_rsp.busy)
        else $error("divider started while busy");

    a_sq_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_req.start |-> !sq_rsp.busy)
        else $error("square root started while busy");

    // x velocities of both agents stay within the speed range
    a_vel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vx[0] <= VEL_LIM) && (r_vx[0] >= -VEL_LIM)
        && (r_vx[1] <= VEL_LIM) && (r_vx[1] >= -VEL_LIM))
        else $error("velocity out of range");

    // an accepted request holds off the next one
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while busy");

endmodule
`default_nettype wire
